// ----- rtl/core/spa_pkg.sv -----
// Shared types and constants for the sparse polynomial adder.
// Used by the front end, command queue, merge back end and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  // Term store depth and derived widths
  localparam int DEPTH   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int EXP_W   = 16;
  localparam int COEF_W  = 32;
  localparam int SUM_W   = COEF_W + 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE       = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST,
    CMD_LOAD_SECOND,
    CMD_MERGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [EXP_W-1:0]           exponent;
    logic signed [COEF_W-1:0]   coefficient;
  } cmd_t;

  typedef struct packed {
    logic [EXP_W-1:0]           exponent;
    logic signed [COEF_W-1:0]   coefficient;
  } term_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/spa_front.sv -----
// Front end: accepts input words, decodes the mode and pushes commands.
// Depends on spa_pkg; feeds spa_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module spa_front import spa_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [MODE_W-1:0]         in_mode,
  input  wire logic [EXP_W-1:0]          in_term_exponent,
  input  wire logic signed [COEF_W-1:0]  in_term_coefficient,
  input  wire fifo_stat_t                q_stat,
  output logic                           push,
  output cmd_t                           push_cmd
);

  logic      known;
  cmd_kind_t kind;

  // Decode mode; the unused code is taken and dropped
  always_comb begin
    known = 1'b1;
    kind  = CMD_MERGE;
    unique case (in_mode)
      MODE_LOAD_FIRST:  kind = CMD_LOAD_FIRST;
      MODE_LOAD_SECOND: kind = CMD_LOAD_SECOND;
      MODE_MERGE:       kind = CMD_MERGE;
      default:          known = 1'b0;
    endcase
  end

  // Hold off the sender while the queue is full
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full && known;

  assign push_cmd.kind        = kind;
  assign push_cmd.exponent    = in_term_exponent;
  assign push_cmd.coefficient = in_term_coefficient;

  // Clock and reset unused: this stage is purely combinational
  logic unused_ok;
  assign unused_ok = clk ^ rst_n;

endmodule

`default_nettype wire

// ----- rtl/core/spa_cmd_fifo.sv -----
// Short command queue between the front end and the merge back end.
// Depends on spa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spa_cmd_fifo import spa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output cmd_t       head_cmd,
  output fifo_stat_t stat
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = entry_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/spa_back.sv -----
// Back end: term stores, list loading and the two-way merge with output register.
// Depends on spa_pkg; takes commands from spa_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module spa_back import spa_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                head_cmd,
  input  wire fifo_stat_t          q_stat,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [EXP_W-1:0]         out_exponent,
  output logic signed [SUM_W-1:0]  out_coefficient,
  output logic                     out_last_term,
  output logic                     out_empty_result,
  output logic                     out_dropped_terms
);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        first_count_r, first_count_nxt;
  logic [CNT_W-1:0]        second_count_r, second_count_nxt;
  logic [CNT_W-1:0]        first_idx_r, first_idx_nxt;
  logic [CNT_W-1:0]        second_idx_r, second_idx_nxt;
  logic                    overflow_r, overflow_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [EXP_W-1:0]        out_exp_r, out_exp_nxt;
  logic signed [SUM_W-1:0] out_coef_r, out_coef_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_empty_r, out_empty_nxt;
  logic                    out_drop_r, out_drop_nxt;

  term_t                   first_mem [DEPTH];
  term_t                   second_mem [DEPTH];
  term_t                   first_head_r, second_head_r;
  logic [ADDR_W-1:0]       first_rd_addr, second_rd_addr;
  logic                    first_wr, second_wr;

  logic                    out_free;
  logic                    has_first, has_second, take_first, take_second;
  logic signed [SUM_W-1:0] first_ext, second_ext;

  assign out_free   = !out_valid_r || !out_stall;
  assign has_first  = first_idx_r < first_count_r;
  assign has_second = second_idx_r < second_count_r;
  assign first_ext  = {first_head_r.coefficient[COEF_W-1], first_head_r.coefficient};
  assign second_ext = {second_head_r.coefficient[COEF_W-1], second_head_r.coefficient};

  // Pick the head with the smaller exponent, both on a tie
  always_comb begin
    take_first  = has_first;
    take_second = has_second;
    if (has_first && has_second) begin
      if (first_head_r.exponent < second_head_r.exponent) begin
        take_second = 1'b0;
      end else if (first_head_r.exponent > second_head_r.exponent) begin
        take_first = 1'b0;
      end
    end
  end

  // Sequence loads and merge steps
  always_comb begin
    state_nxt        = state_r;
    first_count_nxt  = first_count_r;
    second_count_nxt = second_count_r;
    first_idx_nxt    = first_idx_r;
    second_idx_nxt   = second_idx_r;
    overflow_nxt     = overflow_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_exp_nxt      = out_exp_r;
    out_coef_nxt     = out_coef_r;
    out_last_nxt     = out_last_r;
    out_empty_nxt    = out_empty_r;
    out_drop_nxt     = out_drop_r;
    pop              = 1'b0;
    first_wr         = 1'b0;
    second_wr        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          unique case (head_cmd.kind)
            CMD_LOAD_FIRST: begin
              pop = 1'b1;
              if (first_count_r < CNT_W'(DEPTH)) begin
                first_wr        = 1'b1;
                first_count_nxt = first_count_r + 1'b1;
              end else begin
                overflow_nxt = 1'b1;
              end
            end
            CMD_LOAD_SECOND: begin
              pop = 1'b1;
              if (second_count_r < CNT_W'(DEPTH)) begin
                second_wr        = 1'b1;
                second_count_nxt = second_count_r + 1'b1;
              end else begin
                overflow_nxt = 1'b1;
              end
            end
            CMD_MERGE: begin
              if (out_free) begin
                pop = 1'b1;
                if (first_count_r == '0 && second_count_r == '0) begin
                  // Both lists empty: one marked result
                  out_valid_nxt = 1'b1;
                  out_exp_nxt   = '0;
                  out_coef_nxt  = '0;
                  out_last_nxt  = 1'b1;
                  out_empty_nxt = 1'b1;
                  out_drop_nxt  = overflow_r;
                  overflow_nxt  = 1'b0;
                end else begin
                  state_nxt = ST_MERGE;
                end
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = 1'b0;
          out_drop_nxt  = overflow_r;
          if (take_first && take_second) begin
            out_exp_nxt    = first_head_r.exponent;
            out_coef_nxt   = first_ext + second_ext;
            first_idx_nxt  = first_idx_r + 1'b1;
            second_idx_nxt = second_idx_r + 1'b1;
          end else if (take_first) begin
            out_exp_nxt   = first_head_r.exponent;
            out_coef_nxt  = first_ext;
            first_idx_nxt = first_idx_r + 1'b1;
          end else begin
            out_exp_nxt    = second_head_r.exponent;
            out_coef_nxt   = second_ext;
            second_idx_nxt = second_idx_r + 1'b1;
          end
          out_last_nxt = (first_idx_nxt >= first_count_r) &&
                         (second_idx_nxt >= second_count_r);
          // Last term: clear both lists and the overflow mark
          if (out_last_nxt) begin
            state_nxt        = ST_IDLE;
            first_count_nxt  = '0;
            second_count_nxt = '0;
            first_idx_nxt    = '0;
            second_idx_nxt   = '0;
            overflow_nxt     = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      first_count_r  <= '0;
      second_count_r <= '0;
      first_idx_r    <= '0;
      second_idx_r   <= '0;
      overflow_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      first_count_r  <= first_count_nxt;
      second_count_r <= second_count_nxt;
      first_idx_r    <= first_idx_nxt;
      second_idx_r   <= second_idx_nxt;
      overflow_r     <= overflow_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_exp_r   <= out_exp_nxt;
    out_coef_r  <= out_coef_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  // Read the store at the next head index so the head is ready each cycle
  assign first_rd_addr  = (first_idx_nxt < CNT_W'(DEPTH)) ?
                          first_idx_nxt[ADDR_W-1:0] : '0;
  assign second_rd_addr = (second_idx_nxt < CNT_W'(DEPTH)) ?
                          second_idx_nxt[ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (first_wr) begin
      first_mem[first_count_r[ADDR_W-1:0]] <= {head_cmd.exponent, head_cmd.coefficient};
    end
    first_head_r <= first_mem[first_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (second_wr) begin
      second_mem[second_count_r[ADDR_W-1:0]] <= {head_cmd.exponent, head_cmd.coefficient};
    end
    second_head_r <= second_mem[second_rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_exponent      = out_exp_r;
  assign out_coefficient   = out_coef_r;
  assign out_last_term     = out_last_r;
  assign out_empty_result  = out_empty_r;
  assign out_dropped_terms = out_drop_r;

`ifndef NO_ASSERTIONS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_idx_r <= first_count_r && second_idx_r <= second_count_r)
    else $error("merge index ran past list length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_count_r <= CNT_W'(DEPTH) && second_count_r <= CNT_W'(DEPTH))
    else $error("list count beyond store depth");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> first_idx_r == '0 && second_idx_r == '0)
    else $error("merge indices not cleared in idle");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r)
    else $error("empty result not marked last");

  a_merge_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MERGE && out_free && out_last_nxt |=>
      state_r == ST_IDLE && first_count_r == '0 && !overflow_r)
    else $error("lists not cleared after merge");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sparse_polynomial_add_top.sv -----
// Sparse polynomial adder top level: simple valid/stall channels in and out.
// Load words (mode 0 / mode 1) append a term to the first or second list; a merge
// word (mode 2) walks both lists in exponent order and emits one result per term,
// summing coefficients on equal exponents. Mode 3 words are taken and ignored.
// Loads retire at one per cycle while no merge is running. A merge word is popped
// from the queue in the idle state and the engine then writes its results to the
// output register at one result per cycle while the receiver keeps stall low; an
// empty merge writes its single marked result straight from the idle state.
// A two-word command queue sits between the front end and the merge engine, so
// new words are taken while results wait; in_stall rises once it is full.
// When out_stall is high the output register holds its word and merge steps wait.
// Reset (rst_n low, synchronous) empties the queue, both lists and the overflow
// mark; term store contents are left as they were and never used before written.
// Depends on spa_pkg, spa_front, spa_cmd_fifo and spa_back.
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_add_top import spa_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [MODE_W-1:0]         in_mode,
  input  wire logic [EXP_W-1:0]          in_term_exponent,
  input  wire logic signed [COEF_W-1:0]  in_term_coefficient,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [EXP_W-1:0]               out_exponent,
  output logic signed [SUM_W-1:0]        out_coefficient,
  output logic                           out_last_term,
  output logic                           out_empty_result,
  output logic                           out_dropped_terms
);

  fifo_stat_t q_stat;
  logic       push, pop;
  cmd_t       push_cmd, head_cmd;

  // Decode and queue input words
  spa_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_term_exponent    (in_term_exponent),
    .in_term_coefficient (in_term_coefficient),
    .q_stat              (q_stat),
    .push                (push),
    .push_cmd            (push_cmd)
  );

  spa_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // Load lists and run merges
  spa_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_cmd          (head_cmd),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_exponent      (out_exponent),
    .out_coefficient   (out_coefficient),
    .out_last_term     (out_last_term),
    .out_empty_result  (out_empty_result),
    .out_dropped_terms (out_dropped_terms)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the sparse polynomial adder top level.
// Holds a small scoreboard class that mirrors both term lists and predicts every result word.
// Depends on spa_pkg and sparse_polynomial_add_top.
`timescale 1ns / 1ps

module tb;
  import spa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WORD_TARGET = 270;
  localparam int QUIET_FROM  = 225;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_CAP  = 40;

  // Shapes of a random word group
  typedef enum int {GRP_SORTED, GRP_OVERFLOW, GRP_NOISE} group_kind_t;

  typedef struct {
    logic [EXP_W-1:0]         exponent;
    logic signed [SUM_W-1:0]  coefficient;
    logic                     is_last;
    logic                     is_empty;
    logic                     dropped;
  } sum_term_t;

  // Mirror of both term lists and queue of predicted sum terms
  class term_merge_board;
    term_t       first_store[DEPTH];
    term_t       second_store[DEPTH];
    int unsigned first_len;
    int unsigned second_len;
    bit          overflow_seen;
    sum_term_t   pending_terms[$];
    int unsigned fail_count;
    int unsigned checked_count;
    int unsigned merge_count;
    int unsigned overflow_merges;

    function void note_word(logic [MODE_W-1:0] mode, logic [EXP_W-1:0] e,
                            logic signed [COEF_W-1:0] c);
      int unsigned i;
      int unsigned j;
      bit          take_a;
      bit          take_b;
      bit          drop;
      sum_term_t   t;
      case (mode)
        MODE_LOAD_FIRST: begin
          if (first_len >= DEPTH) overflow_seen = 1'b1;
          else begin
            first_store[first_len] = '{exponent: e, coefficient: c};
            first_len++;
          end
        end
        MODE_LOAD_SECOND: begin
          if (second_len >= DEPTH) overflow_seen = 1'b1;
          else begin
            second_store[second_len] = '{exponent: e, coefficient: c};
            second_len++;
          end
        end
        MODE_MERGE: begin
          i = 0;
          j = 0;
          drop = overflow_seen;
          merge_count++;
          if (drop) overflow_merges++;
          if (first_len + second_len == 0) begin
            t = '{exponent: '0, coefficient: '0, is_last: 1'b1, is_empty: 1'b1, dropped: drop};
            pending_terms.push_back(t);
          end
          // Walk both heads, taking the lower exponent or the sum on a tie
          while (i < first_len || j < second_len) begin
            take_a = i < first_len;
            take_b = j < second_len;
            if (take_a && take_b) begin
              if (first_store[i].exponent < second_store[j].exponent) take_b = 1'b0;
              else if (first_store[i].exponent > second_store[j].exponent) take_a = 1'b0;
            end
            if (take_a && take_b) begin
              t.exponent    = first_store[i].exponent;
              t.coefficient = SUM_W'($signed(first_store[i].coefficient))
                            + SUM_W'($signed(second_store[j].coefficient));
              i++;
              j++;
            end else if (take_a) begin
              t.exponent    = first_store[i].exponent;
              t.coefficient = SUM_W'($signed(first_store[i].coefficient));
              i++;
            end else begin
              t.exponent    = second_store[j].exponent;
              t.coefficient = SUM_W'($signed(second_store[j].coefficient));
              j++;
            end
            t.is_last  = (i >= first_len) && (j >= second_len);
            t.is_empty = 1'b0;
            t.dropped  = drop;
            pending_terms.push_back(t);
          end
          first_len     = 0;
          second_len    = 0;
          overflow_seen = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void report_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    endfunction

    function void check_term(logic [EXP_W-1:0] e, logic signed [SUM_W-1:0] c,
                             logic l, logic em, logic d);
      sum_term_t want;
      if (pending_terms.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP)
          $display("%0t: unexpected result word: expected none, got exponent %0d coefficient %0d",
                   $time, e, c);
        return;
      end
      want = pending_terms.pop_front();
      checked_count++;
      if (want.exponent !== e)     report_field("exponent", {48'd0, want.exponent}, {48'd0, e});
      if (want.coefficient !== c)  report_field("coefficient", want.coefficient, c);
      if (want.is_last !== l)      report_field("last_term", {63'd0, want.is_last}, {63'd0, l});
      if (want.is_empty !== em)    report_field("empty_result", {63'd0, want.is_empty}, {63'd0, em});
      if (want.dropped !== d)      report_field("dropped_terms", {63'd0, want.dropped}, {63'd0, d});
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [MODE_W-1:0]         in_mode;
  logic [EXP_W-1:0]          in_term_exponent;
  logic signed [COEF_W-1:0]  in_term_coefficient;
  logic                      out_valid;
  logic                      out_stall;
  logic [EXP_W-1:0]          out_exponent;
  logic signed [SUM_W-1:0]   out_coefficient;
  logic                      out_last_term;
  logic                      out_empty_result;
  logic                      out_dropped_terms;

  term_merge_board board;
  bit              in_idle_on;
  bit              out_idle_on;
  int unsigned     words_sent;
  int unsigned     cycle_count;

  sparse_polynomial_add_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_term_exponent    (in_term_exponent),
    .in_term_coefficient (in_term_coefficient),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_exponent        (out_exponent),
    .out_coefficient     (out_coefficient),
    .out_last_term       (out_last_term),
    .out_empty_result    (out_empty_result),
    .out_dropped_terms   (out_dropped_terms)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words still awaited", $time,
               board.pending_terms.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Check each result word taken at the coming edge, sampled while settled
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_term(out_exponent, out_coefficient, out_last_term,
                       out_empty_result, out_dropped_terms);
  end

  // Stall the result channel in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_idle_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one word, hold it until taken, then note it
  task automatic send_word(logic [MODE_W-1:0] mode, logic [EXP_W-1:0] e,
                           logic signed [COEF_W-1:0] c);
    bit taken;
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_mode             <= mode;
    in_term_exponent    <= e;
    in_term_coefficient <= c;
    forever begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
      if (taken) break;
    end
    board.note_word(mode, e, c);
    if (mode != MODE_UNUSED) words_sent++;
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coefficient();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4:       return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // One group of loads into both lists, interleaved, closed by a merge
  task automatic run_term_group(group_kind_t kind);
    term_t            a_terms[$];
    term_t            b_terms[$];
    term_t            t;
    int unsigned      n_a;
    int unsigned      n_b;
    logic [EXP_W-1:0] base;
    logic [EXP_W-1:0] e;
    int unsigned      k;
    case ($urandom_range(0, 3))
      0:       base = EXP_W'(16'hffff - $urandom_range(0, 40));
      1:       base = EXP_W'($urandom);
      default: base = EXP_W'($urandom_range(0, 8));
    endcase
    n_a = ($urandom_range(0, 7) == 0) ? $urandom_range(7, DEPTH) : $urandom_range(0, 6);
    n_b = ($urandom_range(0, 7) == 0) ? $urandom_range(7, DEPTH) : $urandom_range(0, 6);
    if (kind == GRP_OVERFLOW) begin
      if ($urandom_range(0, 1)) n_a = DEPTH + $urandom_range(1, 3);
      else n_b = DEPTH + $urandom_range(1, 3);
    end
    // Shared base and short steps make equal exponents across the lists common
    e = base;
    for (k = 0; k < n_a; k++) begin
      t.exponent    = (kind == GRP_NOISE) ? EXP_W'($urandom) : e;
      t.coefficient = pick_coefficient();
      a_terms.push_back(t);
      e = e + EXP_W'($urandom_range(1, 3));
    end
    e = base + EXP_W'($urandom_range(0, 2));
    for (k = 0; k < n_b; k++) begin
      t.exponent    = (kind == GRP_NOISE) ? EXP_W'($urandom) : e;
      t.coefficient = pick_coefficient();
      b_terms.push_back(t);
      e = e + EXP_W'($urandom_range(1, 3));
    end
    while (a_terms.size() != 0 || b_terms.size() != 0) begin
      if ($urandom_range(0, 14) == 0)
        send_word(MODE_UNUSED, EXP_W'($urandom), $urandom);
      if (a_terms.size() != 0 && (b_terms.size() == 0 || $urandom_range(0, 1))) begin
        t = a_terms.pop_front();
        send_word(MODE_LOAD_FIRST, t.exponent, t.coefficient);
      end else begin
        t = b_terms.pop_front();
        send_word(MODE_LOAD_SECOND, t.exponent, t.coefficient);
      end
    end
    send_word(MODE_MERGE, EXP_W'($urandom), $urandom);
  endtask

  initial begin
    int unsigned group_index;
    group_kind_t kind;
    in_valid            <= 1'b0;
    in_mode             <= MODE_LOAD_FIRST;
    in_term_exponent    <= '0;
    in_term_coefficient <= '0;
    rst_n               <= 1'b0;
    cycle_count         = 0;
    words_sent          = 0;
    in_idle_on          = 1'b1;
    out_idle_on         = 1'b1;
    board               = new;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty merge, with the ignored fields at their extremes
    send_word(MODE_MERGE, 16'hffff, 32'sh7fff_ffff);
    send_word(MODE_UNUSED, 16'hffff, 32'sh8000_0000);
    // Extreme sums, a zero sum and an unused word mid-list
    send_word(MODE_LOAD_FIRST, 16'd0, 32'sh8000_0000);
    send_word(MODE_LOAD_SECOND, 16'd0, 32'sh8000_0000);
    send_word(MODE_LOAD_FIRST, 16'd7, 32'sd5);
    send_word(MODE_UNUSED, 16'd7, -32'sd1);
    send_word(MODE_LOAD_SECOND, 16'd9, -32'sd3);
    send_word(MODE_LOAD_FIRST, 16'd100, 32'sd5);
    send_word(MODE_LOAD_SECOND, 16'd100, -32'sd5);
    send_word(MODE_LOAD_FIRST, 16'hffff, 32'sh7fff_ffff);
    send_word(MODE_LOAD_SECOND, 16'hffff, 32'sh7fff_ffff);
    send_word(MODE_MERGE, 16'd0, 32'sd0);
    // One list only on each side
    send_word(MODE_LOAD_FIRST, 16'd3, 32'sd1);
    send_word(MODE_MERGE, 16'd0, 32'sd0);
    send_word(MODE_LOAD_SECOND, 16'd4, -32'sd1);
    send_word(MODE_MERGE, 16'd0, 32'sd0);
    // Unsorted loads: only the heads are compared
    send_word(MODE_LOAD_FIRST, 16'd50, 32'sd1);
    send_word(MODE_LOAD_FIRST, 16'd10, 32'sd2);
    send_word(MODE_LOAD_SECOND, 16'd20, 32'sd3);
    send_word(MODE_LOAD_SECOND, 16'd5, -32'sd7);
    send_word(MODE_MERGE, 16'd0, 32'sd0);

    // Random groups; mostly sorted, some overflowing, some noise
    group_index = 0;
    while (words_sent < WORD_TARGET) begin
      if (words_sent > QUIET_FROM) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      case ($urandom_range(0, 9))
        0:       kind = GRP_OVERFLOW;
        1:       kind = GRP_NOISE;
        default: kind = GRP_SORTED;
      endcase
      if (group_index == 2) kind = GRP_OVERFLOW;
      run_term_group(kind);
      group_index++;
    end
    // Drop valid at the edge that took the last word
    in_valid <= 1'b0;

    // Drain, then allow a little longer for stray words
    while (board.pending_terms.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d load and merge words across %0d merges (%0d with dropped terms).",
             words_sent, board.merge_count, board.overflow_merges);
    $display("Checked %0d result words.", board.checked_count);
    if (board.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
